// ===== hw/rtl/cpr_pkg.sv =====
// cpr_pkg: shared types, codes and constant tables of the camera pose rotator.
// Holds the sequencer state type, opcodes, register indexes and the Q30 sin/cos
// tables. Depends on nothing.
package cpr_pkg;

   // Field and port widths
   localparam int COORD_W      = 32;
   localparam int TURN_W       = 10;
   localparam int OPCODE_W     = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int NUM_CSR      = 6;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 192;
   localparam int COORD_FRAC_BITS = 16;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_ORBIT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FIRST  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELOAD = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_EYE_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_EYE_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_EYE_Z    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_TARGET_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_TARGET_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_TARGET_Z = 3'd5;

   // Reset pose: eye five units out on z, target at the origin
   localparam coord_type START_EYE_Z_RST = coord_type'(32'sd5 <<< COORD_FRAC_BITS);

   // Turn limit in degrees
   localparam int DEG_MAX = 180;
   localparam int DEG_QUARTER = 90;
   localparam int DEG_EIGHTH = 45;

   // Iteration counts of the shared sqrt and divide steps and of the MAC steps
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 33;
   localparam int VEC_MAC_STEPS = 3;
   localparam int ROT_MAC_STEPS = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQV,
      ST_CHKV,
      ST_ROT,
      ST_FIXW,
      ST_SQW,
      ST_CHKW,
      ST_SQRT,
      ST_MUL,
      ST_DIVI,
      ST_DIV,
      ST_WRITE,
      ST_NEXT,
      ST_DONE
   } cpr_state_type;

   // Saturate to the signed 32-bit range
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   function automatic coord_type sat32(input logic signed [65:0] v);
      coord_type r;
      if (v > SAT_HI) begin
         r = coord_type'(SAT_HI[31:0]);
      end else if (v < SAT_LO) begin
         r = coord_type'(SAT_LO[31:0]);
      end else begin
         r = coord_type'(v[31:0]);
      end
      return r;
   endfunction

   // Q30 sin/cos for 0..45 degrees, Taylor series built at elaboration
   localparam int TRIG_TAB_N = 46;
   localparam logic [63:0] PI_Q30   = 64'd3373259426;
   localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF = 64'd1 << 29;

   typedef logic [TRIG_TAB_N-1:0][30:0] trig_tab_type;

   function automatic logic [63:0] qmul30(input logic [63:0] a, input logic [63:0] b);
      return (a * b + Q30_HALF) >> 30;
   endfunction

   function automatic trig_tab_type build_trig(input logic want_cos);
      trig_tab_type tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] sum;
      tab = '0;
      for (int a = 0; a < TRIG_TAB_N; a++) begin
         x  = (64'(a) * PI_Q30 + 64'd90) / 64'd180;
         x2 = qmul30(x, x);
         if (want_cos) begin
            t   = Q30_ONE;
            sum = Q30_ONE;
            t = (qmul30(t, x2) + 64'd1) / 64'd2;    sum = sum - t;
            t = (qmul30(t, x2) + 64'd6) / 64'd12;   sum = sum + t;
            t = (qmul30(t, x2) + 64'd15) / 64'd30;  sum = sum - t;
            t = (qmul30(t, x2) + 64'd28) / 64'd56;  sum = sum + t;
            t = (qmul30(t, x2) + 64'd45) / 64'd90;  sum = sum - t;
         end else begin
            t   = x;
            sum = x;
            t = (qmul30(t, x2) + 64'd3) / 64'd6;    sum = sum - t;
            t = (qmul30(t, x2) + 64'd10) / 64'd20;  sum = sum + t;
            t = (qmul30(t, x2) + 64'd21) / 64'd42;  sum = sum - t;
            t = (qmul30(t, x2) + 64'd36) / 64'd72;  sum = sum + t;
         end
         tab[a] = sum[30:0];
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_Q30 = build_trig(1'b0);
   localparam trig_tab_type COS_Q30 = build_trig(1'b1);

endpackage

// ===== hw/rtl/camera_pose_rotator.sv =====
// camera_pose_rotator: orbit and first-person camera turns in fixed point.
// Uses cpr_pkg for types, codes and the sin/cos tables.
//
// Usage:
//  - req channel: one transfer per mouse turn. req_tuser holds the opcode
//    (0 orbit, 1 first person, 2 reload pose from the csr registers).
//    req_tdata holds turn_x and turn_y in whole degrees.
//  - rsp channel: one transfer per request carrying the whole pose.
//  - csr channel: writes the six start registers; always ready. Write only
//    while the block is idle.
//  - Throughput: one request at a time; req_tready is high only while the
//    sequencer is idle. A turn runs two rotations: one shared 33x33
//    multiplier does all products, a 2-bit-per-step square root runs 32
//    steps twice and a 1-bit-per-step divider runs 33 steps for each of the
//    three components. A rotation of a zero vector is skipped.
//  - Reset loads the start registers and the pose with 0,0,5.0 / 0,0,0.
//  - A stalled receiver holds the result in the output register; the next
//    request is accepted meanwhile and waits at its end until the register
//    is free.
module camera_pose_rotator #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = opcode; tdata = turn_x[9:0], turn_y[19:10], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cpr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [cpr_pkg::OPCODE_W-1:0]      req_tuser,
   // response: tdata = eye_x, eye_y, eye_z, target_x, target_y, target_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cpr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cpr_pkg::COORD_W-1:0]       csr_data
);
   import cpr_pkg::*;

   localparam int TW      = TRIG_FRAC_BITS + 2;
   localparam int TRIG_SH = 30 - TRIG_FRAC_BITS;
   localparam logic [32:0] TRIG_HALF = 33'd1 << (TRIG_SH - 1);

   // Control and pose registers
   cpr_state_type state_ff, state_in;
   coord_type     cfg_ff [NUM_CSR];
   coord_type     cfg_in [NUM_CSR];
   coord_type     eye_ff [3];
   coord_type     eye_in [3];
   coord_type     tgt_ff [3];
   coord_type     tgt_in [3];
   logic [5:0]    cnt_ff, cnt_in;
   logic          rot_ff, rot_in;
   logic          mode_ff, mode_in;
   logic          pass_ff, pass_in;
   logic [1:0]    comp_ff, comp_in;
   logic signed [TURN_W-1:0] ang1_ff, ang1_in;
   logic signed [TURN_W-1:0] ang2_ff, ang2_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   coord_type     v_ff [3];
   coord_type     v_in [3];
   coord_type     w_ff [3];
   coord_type     w_in [3];
   logic signed [TW-1:0] sin_ff, sin_in;
   logic signed [TW-1:0] cos_ff, cos_in;
   logic signed [65:0]   prod_ff, prod_in;
   logic [63:0]   m2_ff, m2_in;
   logic [63:0]   w2_ff, w2_in;
   logic signed [63:0] acc_a_ff, acc_a_in;
   logic signed [63:0] acc_b_ff, acc_b_in;
   logic [63:0]   sq_src_ff, sq_src_in;
   logic [33:0]   sq_rem_ff, sq_rem_in;
   logic [31:0]   sq_root_ff, sq_root_in;
   logic [31:0]   m_ff, m_in;
   logic [31:0]   mw_ff, mw_in;
   logic [32:0]   dv_num_ff, dv_num_in;
   logic [31:0]   dv_rem_ff, dv_rem_in;
   logic [32:0]   dv_q_ff, dv_q_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic          req_xfer;
   logic [OPCODE_W-1:0] op_c;
   logic signed [TURN_W-1:0] tx_c, ty_c, tx_sat_c, ty_sat_c;
   coord_type     base_c [3];
   coord_type     mov_c [3];
   coord_type     vp_c, vq_c;
   logic signed [TURN_W-1:0] deg_c;
   logic [8:0]    deg_mag_c;
   logic [6:0]    fold_c;
   logic          cneg_c;
   logic [5:0]    tab_idx_c;
   logic [30:0]   sq_c, cq_c;
   logic [TW-2:0] s_mag_c, c_mag_c;
   logic signed [32:0] mul_a_c, mul_b_c;
   logic [1:0]    sel_c;
   logic [31:0]   w_abs_c;
   logic [35:0]   sq_t_c, sq_trial_c;
   logic          sq_ge_c;
   logic [31:0]   sq_root_n_c;
   logic [32:0]   dv_t_c;
   logic          dv_ge_c;
   logic [63:0]   dividend_c;
   logic signed [34:0] q_ext_c, sr_c, sum_c;
   coord_type     wp_c, wq_c;

   function automatic logic signed [63:0] round_trig(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + (64'd1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Request fields with turns clamped to +-180
   assign op_c = req_tuser;
   assign tx_c = $signed(req_tdata[9:0]);
   assign ty_c = $signed(req_tdata[19:10]);
   always_comb begin
      tx_sat_c = tx_c;
      if (tx_c > 10'(DEG_MAX)) tx_sat_c = 10'(DEG_MAX);
      if (tx_c < -10'(DEG_MAX)) tx_sat_c = -10'(DEG_MAX);
      ty_sat_c = ty_c;
      if (ty_c > 10'(DEG_MAX)) ty_sat_c = 10'(DEG_MAX);
      if (ty_c < -10'(DEG_MAX)) ty_sat_c = -10'(DEG_MAX);
   end

   // Base (fixed) and moving points; planes of the two rotations
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base_c[i] = mode_ff ? eye_ff[i] : tgt_ff[i];
         mov_c[i]  = mode_ff ? tgt_ff[i] : eye_ff[i];
      end
      vp_c = rot_ff ? v_ff[2] : v_ff[1];
      vq_c = rot_ff ? v_ff[0] : v_ff[2];
   end

   // Sine and cosine by table lookup and symmetry
   always_comb begin
      deg_c     = rot_ff ? ang2_ff : ang1_ff;
      deg_mag_c = deg_c[TURN_W-1] ? 9'(-deg_c) : 9'(deg_c);
      cneg_c    = (deg_mag_c > 9'(DEG_QUARTER));
      fold_c    = cneg_c ? 7'(9'(DEG_MAX) - deg_mag_c) : deg_mag_c[6:0];
      if (fold_c <= 7'(DEG_EIGHTH)) begin
         tab_idx_c = fold_c[5:0];
         sq_c = SIN_Q30[tab_idx_c];
         cq_c = COS_Q30[tab_idx_c];
      end else begin
         tab_idx_c = 6'(7'(DEG_QUARTER) - fold_c);
         sq_c = COS_Q30[tab_idx_c];
         cq_c = SIN_Q30[tab_idx_c];
      end
      s_mag_c = (TW-1)'((33'(sq_c) + TRIG_HALF) >> TRIG_SH);
      c_mag_c = (TW-1)'((33'(cq_c) + TRIG_HALF) >> TRIG_SH);
   end

   // Shared multiplier operand select
   always_comb begin
      sel_c   = (cnt_ff[1:0] == 2'd3) ? 2'd0 : cnt_ff[1:0];
      w_abs_c = w_ff[comp_ff][31] ? 32'(-w_ff[comp_ff]) : 32'(w_ff[comp_ff]);
      mul_a_c = '0;
      mul_b_c = '0;
      case (state_ff)
         ST_SQV: begin
            mul_a_c = 33'(v_ff[sel_c]);
            mul_b_c = 33'(v_ff[sel_c]);
         end
         ST_SQW: begin
            mul_a_c = 33'(w_ff[sel_c]);
            mul_b_c = 33'(w_ff[sel_c]);
         end
         ST_ROT: begin
            case (cnt_ff[1:0])
               2'd0: begin mul_a_c = 33'(cos_ff); mul_b_c = 33'(vp_c); end
               2'd1: begin mul_a_c = 33'(sin_ff); mul_b_c = 33'(vq_c); end
               2'd2: begin mul_a_c = 33'(sin_ff); mul_b_c = 33'(vp_c); end
               default: begin mul_a_c = 33'(cos_ff); mul_b_c = 33'(vq_c); end
            endcase
         end
         ST_MUL: begin
            mul_a_c = $signed({1'b0, w_abs_c});
            mul_b_c = $signed({1'b0, m_ff});
         end
         default: begin
            mul_a_c = '0;
            mul_b_c = '0;
         end
      endcase
      prod_in = mul_a_c * mul_b_c;
   end

   // Square root and divide steps
   always_comb begin
      sq_t_c      = {sq_rem_ff, sq_src_ff[63:62]};
      sq_trial_c  = {2'b00, sq_root_ff, 2'b01};
      sq_ge_c     = (sq_t_c >= sq_trial_c);
      sq_root_n_c = {sq_root_ff[30:0], sq_ge_c};
      dv_t_c      = {dv_rem_ff, dv_num_ff[32]};
      dv_ge_c     = (dv_t_c >= {1'b0, mw_ff});
      dividend_c  = prod_ff[63:0] + {33'd0, mw_ff[31:1]};
      q_ext_c     = $signed({2'b00, dv_q_ff});
      sr_c        = w_ff[comp_ff][31] ? -q_ext_c : q_ext_c;
      sum_c       = 35'(base_c[comp_ff]) + sr_c;
      wp_c        = sat32(66'(round_trig(acc_a_ff)));
      wq_c        = sat32(66'(round_trig(acc_b_ff)));
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (op_c == OP_ORBIT || op_c == OP_FIRST) state_in = ST_DIFF;
               else state_in = ST_DONE;
            end
         end
         ST_DIFF:  state_in = ST_SQV;
         ST_SQV:   if (cnt_ff == 6'(VEC_MAC_STEPS)) state_in = ST_CHKV;
         ST_CHKV:  state_in = (m2_ff == '0) ? ST_NEXT : ST_ROT;
         ST_ROT:   if (cnt_ff == 6'(ROT_MAC_STEPS)) state_in = ST_FIXW;
         ST_FIXW:  state_in = ST_SQW;
         ST_SQW:   if (cnt_ff == 6'(VEC_MAC_STEPS)) state_in = ST_CHKW;
         ST_CHKW:  state_in = (w2_ff == '0) ? ST_NEXT : ST_SQRT;
         ST_SQRT:  if (cnt_ff == 6'(SQRT_STEPS - 1) && pass_ff) state_in = ST_MUL;
         ST_MUL:   state_in = ST_DIVI;
         ST_DIVI:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_WRITE;
         ST_WRITE: state_in = (comp_ff == 2'd2) ? ST_NEXT : ST_MUL;
         ST_NEXT:  state_in = rot_ff ? ST_DONE : ST_DIFF;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: register updates
   always_comb begin
      cfg_in      = cfg_ff;
      eye_in      = eye_ff;
      tgt_in      = tgt_ff;
      cnt_in      = '0;
      rot_in      = rot_ff;
      mode_in     = mode_ff;
      pass_in     = pass_ff;
      comp_in     = comp_ff;
      ang1_in     = ang1_ff;
      ang2_in     = ang2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      sin_in      = sin_ff;
      cos_in      = cos_ff;
      m2_in       = m2_ff;
      w2_in       = w2_ff;
      acc_a_in    = acc_a_ff;
      acc_b_in    = acc_b_ff;
      sq_src_in   = sq_src_ff;
      sq_rem_in   = sq_rem_ff;
      sq_root_in  = sq_root_ff;
      m_in        = m_ff;
      mw_in       = mw_ff;
      dv_num_in   = dv_num_ff;
      dv_rem_in   = dv_rem_ff;
      dv_q_in     = dv_q_ff;

      // register writes
      if (csr_valid) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) cfg_in[i] = coord_type'(csr_data);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in = (op_c == OP_FIRST);
               rot_in  = 1'b0;
               if (op_c == OP_FIRST) begin
                  ang1_in = -ty_sat_c;
                  ang2_in = -tx_sat_c;
               end else begin
                  ang1_in = ty_sat_c[TURN_W-1] ? -ty_sat_c : ty_sat_c;
                  ang2_in = tx_sat_c;
               end
               if (op_c == OP_RELOAD) begin
                  eye_in[0] = cfg_ff[CSR_START_EYE_X];
                  eye_in[1] = cfg_ff[CSR_START_EYE_Y];
                  eye_in[2] = cfg_ff[CSR_START_EYE_Z];
                  tgt_in[0] = cfg_ff[CSR_START_TARGET_X];
                  tgt_in[1] = cfg_ff[CSR_START_TARGET_Y];
                  tgt_in[2] = cfg_ff[CSR_START_TARGET_Z];
               end
            end
         end
         // difference vector and trig values of this rotation
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = sat32(66'(33'(mov_c[i]) - 33'(base_c[i])));
            end
            sin_in = deg_c[TURN_W-1] ? -$signed({1'b0, s_mag_c}) : $signed({1'b0, s_mag_c});
            cos_in = cneg_c ? -$signed({1'b0, c_mag_c}) : $signed({1'b0, c_mag_c});
            m2_in  = '0;
         end
         // squared length; each product is registered and summed in the cycle after its operands
         ST_SQV: begin
            if (cnt_ff != '0) m2_in = m2_ff + prod_ff[63:0];
            if (cnt_ff != 6'(VEC_MAC_STEPS)) cnt_in = cnt_ff + 6'd1;
         end
         ST_SQW: begin
            if (cnt_ff != '0) w2_in = w2_ff + prod_ff[63:0];
            if (cnt_ff != 6'(VEC_MAC_STEPS)) cnt_in = cnt_ff + 6'd1;
         end
         // plane rotation: a = c*p - s*q, b = s*p + c*q
         ST_ROT: begin
            case (cnt_ff[2:0])
               3'd1: acc_a_in = prod_ff[63:0];
               3'd2: acc_a_in = acc_a_ff - prod_ff[63:0];
               3'd3: acc_b_in = prod_ff[63:0];
               3'd4: acc_b_in = acc_b_ff + prod_ff[63:0];
               default: acc_a_in = acc_a_ff;
            endcase
            if (cnt_ff != 6'(ROT_MAC_STEPS)) cnt_in = cnt_ff + 6'd1;
         end
         ST_FIXW: begin
            w_in = v_ff;
            if (rot_ff) begin
               w_in[2] = wp_c;
               w_in[0] = wq_c;
            end else begin
               w_in[1] = wp_c;
               w_in[2] = wq_c;
            end
            w2_in = '0;
         end
         ST_CHKW: begin
            sq_src_in  = m2_ff;
            sq_rem_in  = '0;
            sq_root_in = '0;
            pass_in    = 1'b0;
         end
         // two radicand bits and one root bit per step; first pass on m2, second on w2
         ST_SQRT: begin
            sq_rem_in  = sq_ge_c ? 34'(sq_t_c - sq_trial_c) : 34'(sq_t_c);
            sq_root_in = sq_root_n_c;
            sq_src_in  = {sq_src_ff[61:0], 2'b00};
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SQRT_STEPS - 1)) begin
               cnt_in = '0;
               if (!pass_ff) begin
                  m_in       = sq_root_n_c;
                  sq_src_in  = w2_ff;
                  sq_rem_in  = '0;
                  sq_root_in = '0;
                  pass_in    = 1'b1;
               end else begin
                  mw_in   = sq_root_n_c;
                  comp_in = 2'd0;
               end
            end
         end
         // rounded |w|*m / mw; quotient stays below 2^33
         ST_DIVI: begin
            dv_rem_in = {1'b0, dividend_c[63:33]};
            dv_num_in = dividend_c[32:0];
            dv_q_in   = '0;
         end
         ST_DIV: begin
            dv_rem_in = dv_ge_c ? 32'(dv_t_c - {1'b0, mw_ff}) : dv_t_c[31:0];
            dv_num_in = {dv_num_ff[31:0], 1'b0};
            dv_q_in   = {dv_q_ff[31:0], dv_ge_c};
            if (cnt_ff != 6'(DIV_STEPS - 1)) cnt_in = cnt_ff + 6'd1;
         end
         ST_WRITE: begin
            if (mode_ff) tgt_in[comp_ff] = sat32(66'(sum_c));
            else eye_in[comp_ff] = sat32(66'(sum_c));
            comp_in = comp_ff + 2'd1;
         end
         ST_NEXT: begin
            rot_in = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tgt_ff[2], tgt_ff[1], tgt_ff[0],
                               eye_ff[2], eye_ff[1], eye_ff[0]};
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control state, registers and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rot_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         pass_ff      <= 1'b0;
         comp_ff      <= '0;
         for (int i = 0; i < NUM_CSR; i++) cfg_ff[i] <= '0;
         cfg_ff[CSR_START_EYE_Z] <= START_EYE_Z_RST;
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
         eye_ff[2] <= START_EYE_Z_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         mode_ff      <= mode_in;
         pass_ff      <= pass_in;
         comp_ff      <= comp_in;
         cfg_ff       <= cfg_in;
         eye_ff       <= eye_in;
         tgt_ff       <= tgt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ang1_ff     <= ang1_in;
      ang2_ff     <= ang2_in;
      rsp_data_ff <= rsp_data_in;
      v_ff        <= v_in;
      w_ff        <= w_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      prod_ff     <= prod_in;
      m2_ff       <= m2_in;
      w2_ff       <= w2_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      sq_src_ff   <= sq_src_in;
      sq_rem_ff   <= sq_rem_in;
      sq_root_ff  <= sq_root_in;
      m_ff        <= m_in;
      mw_ff       <= mw_in;
      dv_num_ff   <= dv_num_in;
      dv_rem_ff   <= dv_rem_in;
      dv_q_ff     <= dv_q_in;
   end

endmodule
